@@ src/iir_direct_form_one_filter_top_defines.svh @@
// Assertion helpers shared by the filter RTL.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_TOP_DEFINES_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_TOP_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define IIR_CHK(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("iir filter assertion failed");

// Condition in one cycle implies a consequence in the next.
`define IIR_CHK_NEXT(lbl, ck, rs, ante, cons) \
  `IIR_CHK(lbl, ck, rs, (ante) |=> (cons))

`endif

@@ src/iirdf1_pkg.sv @@
`default_nettype none

package iirdf1_pkg;

  // Default filter orders
  localparam int FORWARD_ORDER_DEF  = 10;
  localparam int FEEDBACK_ORDER_DEF = 10;

  // Datapath widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;
  localparam int HIST_W   = 32;
  localparam int ACC_W    = 64;
  localparam int DIGIT_W  = 8;
  localparam int TAP_W    = 4;

  // Feedback term alignment Q.40 -> Q.24
  localparam int FB_SHIFT = 16;
  // Q.24 -> Q16.16 with round half up
  localparam int Y_SHIFT  = 8;
  localparam logic signed [ACC_W-1:0] Y_RND = 64'sd128;
  localparam logic signed [ACC_W-1:0] Y_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] Y_MIN = 64'shFFFF_FFFF_8000_0000;
  // Q16.16 -> 16-bit sample with round half up
  localparam int S_SHIFT = 16;
  localparam logic signed [HIST_W:0] S_RND = 33'sd32768;
  localparam logic signed [HIST_W:0] S_MAX = 33'sd32767;
  localparam logic signed [HIST_W:0] S_MIN = -33'sd32768;

  // Request codes
  localparam logic REQ_FILTER = 1'b0;
  localparam logic REQ_COEF   = 1'b1;
  localparam logic BANK_FWD   = 1'b0;
  localparam logic BANK_FB    = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic                       coef_bank;
    logic [TAP_W-1:0]           tap_number;
    logic signed [COEF_W-1:0]   coef_word;
    logic signed [SAMPLE_W-1:0] sample_in;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } result_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic start;
    logic clear;
    logic feedback;
  } mac_ctl_t;

endpackage

`default_nettype wire

@@ src/iirdf1_mac.sv @@
`default_nettype none

`include "iir_direct_form_one_filter_top_defines.svh"

module iirdf1_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  iirdf1_pkg::mac_ctl_t                  ctl,
  input  logic signed [iirdf1_pkg::COEF_W-1:0]  coef,
  input  logic signed [iirdf1_pkg::HIST_W-1:0]  operand,
  output logic                                  busy,
  output logic                                  done,
  output logic signed [iirdf1_pkg::ACC_W-1:0]   acc
);
  import iirdf1_pkg::*;

  localparam int DIGITS = COEF_W / DIGIT_W;
  localparam int CW     = $clog2(DIGITS);

  logic [COEF_W-1:0]              coef_sr;
  logic signed [HIST_W-1:0]       opnd;
  logic signed [ACC_W-1:0]        prod;
  logic [CW-1:0]                  cnt;
  logic                           acc_phase;
  logic                           feedback;
  logic signed [DIGIT_W:0]        digit;
  logic signed [DIGIT_W+HIST_W:0] part;
  logic signed [ACC_W-1:0]        prod_next;
  logic signed [ACC_W-1:0]        term;

  // One coefficient digit per cycle, most significant (signed) digit first
  always_comb begin
    if (cnt == '0) begin
      digit = {coef_sr[COEF_W-1], coef_sr[COEF_W-1 -: DIGIT_W]};
    end else begin
      digit = {1'b0, coef_sr[COEF_W-1 -: DIGIT_W]};
    end
    part = digit * opnd;
    if (cnt == '0) begin
      prod_next = ACC_W'(part);
    end else begin
      prod_next = (prod <<< DIGIT_W) + ACC_W'(part);
    end
    term = feedback ? -(prod >>> FB_SHIFT) : prod;
  end

  assign done = busy & acc_phase;

  // Digit sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      acc_phase <= 1'b0;
      cnt       <= '0;
    end else if (ctl.start) begin
      busy      <= 1'b1;
      acc_phase <= 1'b0;
      cnt       <= '0;
    end else if (busy && !acc_phase) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DIGITS - 1)) begin
        acc_phase <= 1'b1;
      end
    end else if (done) begin
      busy      <= 1'b0;
      acc_phase <= 1'b0;
    end
  end

  // Operands, partial product and accumulator
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (done) begin
      acc <= acc + term;
    end
    if (ctl.start) begin
      coef_sr  <= coef;
      opnd     <= operand;
      feedback <= ctl.feedback;
    end else if (busy && !acc_phase) begin
      prod    <= prod_next;
      coef_sr <= coef_sr << DIGIT_W;
    end
  end

  `IIR_CHK(a_start_idle, clk, rst, ctl.start |-> !busy)
  `IIR_CHK_NEXT(a_done_single, clk, rst, done, !done)

endmodule

`default_nettype wire

@@ src/iir_direct_form_one_filter_top.sv @@
// Direct-form-I IIR filter with a digit-serial multiply-accumulate unit (8-bit digits).
// Coefficient write: no result.
// Sample: each tap runs load, 4 digits, accumulate; after the last feedback tap the sum
// is saturated (ST_SAT) and rounded (ST_RND), waiting there while the output stalls.
// Requests stall until the result is loaded; the shared MAC unit serialises all taps.
// Reset (synchronous): histories, coefficients and ring position cleared to zero.
`default_nettype none

`include "iir_direct_form_one_filter_top_defines.svh"

module iir_direct_form_one_filter_top #(
  parameter int FORWARD_ORDER  = iirdf1_pkg::FORWARD_ORDER_DEF,
  parameter int FEEDBACK_ORDER = iirdf1_pkg::FEEDBACK_ORDER_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  iirdf1_pkg::req_t     req,
  output logic                 result_valid,
  input  logic                 result_stall,
  output iirdf1_pkg::result_t  result
);
  import iirdf1_pkg::*;

  localparam int RING_DEPTH =
    ((FORWARD_ORDER > FEEDBACK_ORDER) ? FORWARD_ORDER : FEEDBACK_ORDER) + 1;
  localparam int RW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(FORWARD_ORDER + 1);
  localparam int BW = $clog2(FEEDBACK_ORDER + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FWD  = 3'd1;
  localparam logic [2:0] ST_FB   = 3'd2;
  localparam logic [2:0] ST_SAT  = 3'd3;
  localparam logic [2:0] ST_RND  = 3'd4;

  logic [2:0]                 state;
  logic signed [SAMPLE_W-1:0] x_hist [RING_DEPTH];
  logic signed [HIST_W-1:0]   y_hist [RING_DEPTH];
  logic signed [COEF_W-1:0]   b_coef [FORWARD_ORDER+1];
  logic signed [COEF_W-1:0]   a_coef [FEEDBACK_ORDER+1];
  logic [RW-1:0]              pos;
  logic [RW-1:0]              pos_next;
  logic [RW-1:0]              pos_prev;
  logic [RW-1:0]              slot;
  logic [RW-1:0]              slot_prev;
  logic [RW-1:0]              tap;
  logic                       launched;
  logic signed [HIST_W-1:0]   y_val;
  logic                       clip_y;

  logic                       accept;
  logic                       coef_we;
  logic                       sample_we;
  logic                       y_we;
  logic                       out_free;
  logic                       last_fwd;
  logic                       last_fb;

  mac_ctl_t                   ctl;
  logic signed [COEF_W-1:0]   mac_coef;
  logic signed [HIST_W-1:0]   mac_opnd;
  logic                       mac_busy;
  logic                       mac_done;
  logic signed [ACC_W-1:0]    acc;

  logic signed [ACC_W-1:0]    y_wide;
  logic signed [HIST_W-1:0]   y_sat;
  logic                       y_hit;
  logic signed [HIST_W:0]     s_wide;
  logic signed [SAMPLE_W-1:0] s_sat;
  logic                       s_hit;

  // Handshake and ring arithmetic
  always_comb begin
    req_stall = (state != ST_IDLE);
    accept    = req_valid && !req_stall;
    coef_we   = accept && (req.req_type == REQ_COEF);
    sample_we = accept && (req.req_type == REQ_FILTER);
    y_we      = (state == ST_SAT);
    out_free  = !result_valid || !result_stall;
    pos_next  = (pos == RW'(RING_DEPTH - 1)) ? '0 : pos + 1'b1;
    pos_prev  = (pos == '0) ? RW'(RING_DEPTH - 1) : pos - 1'b1;
    slot_prev = (slot == '0) ? RW'(RING_DEPTH - 1) : slot - 1'b1;
    last_fwd  = (tap == RW'(FORWARD_ORDER));
    last_fb   = (tap == RW'(FEEDBACK_ORDER));
  end

  // MAC operand selection
  always_comb begin
    ctl.start    = ((state == ST_FWD) || (state == ST_FB)) && !mac_busy && !launched;
    ctl.clear    = sample_we;
    ctl.feedback = (state == ST_FB);
    if (state == ST_FB) begin
      mac_coef = a_coef[tap[BW-1:0]];
      mac_opnd = y_hist[slot];
    end else begin
      mac_coef = b_coef[tap[FW-1:0]];
      mac_opnd = HIST_W'(x_hist[slot]);
    end
  end

  iirdf1_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .coef    (mac_coef),
    .operand (mac_opnd),
    .busy    (mac_busy),
    .done    (mac_done),
    .acc     (acc)
  );

  // Q.24 sum to saturated Q16.16, then to saturated 16-bit sample
  always_comb begin
    y_wide = (acc + Y_RND) >>> Y_SHIFT;
    y_hit  = 1'b0;
    if (y_wide > Y_MAX) begin
      y_sat = HIST_W'(Y_MAX);
      y_hit = 1'b1;
    end else if (y_wide < Y_MIN) begin
      y_sat = HIST_W'(Y_MIN);
      y_hit = 1'b1;
    end else begin
      y_sat = HIST_W'(y_wide);
    end
    s_wide = ((HIST_W+1)'(y_val) + S_RND) >>> S_SHIFT;
    s_hit  = 1'b0;
    if (s_wide > S_MAX) begin
      s_sat = SAMPLE_W'(S_MAX);
      s_hit = 1'b1;
    end else if (s_wide < S_MIN) begin
      s_sat = SAMPLE_W'(S_MIN);
      s_hit = 1'b1;
    end else begin
      s_sat = SAMPLE_W'(s_wide);
    end
  end

  // Histories and coefficient banks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        x_hist[i] <= '0;
        y_hist[i] <= '0;
      end
      for (int i = 0; i <= FORWARD_ORDER; i++) begin
        b_coef[i] <= '0;
      end
      for (int i = 0; i <= FEEDBACK_ORDER; i++) begin
        a_coef[i] <= '0;
      end
    end else begin
      if (sample_we) begin
        x_hist[pos_next] <= req.sample_in;
      end
      if (y_we) begin
        y_hist[pos] <= y_sat;
      end
      for (int i = 0; i <= FORWARD_ORDER; i++) begin
        if (coef_we && (req.coef_bank == BANK_FWD) && (int'(req.tap_number) == i)) begin
          b_coef[i] <= req.coef_word;
        end
      end
      for (int i = 1; i <= FEEDBACK_ORDER; i++) begin
        if (coef_we && (req.coef_bank == BANK_FB) && (int'(req.tap_number) == i)) begin
          a_coef[i] <= req.coef_word;
        end
      end
    end
  end

  // Tap sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pos          <= '0;
      launched     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // A new result loaded in the rounding state replaces the one taken
      if (result_valid && !result_stall && (state != ST_RND)) begin
        result_valid <= 1'b0;
      end
      if (ctl.start) begin
        launched <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_we) begin
            pos   <= pos_next;
            slot  <= pos_next;
            tap   <= '0;
            state <= ST_FWD;
          end
        end
        ST_FWD: begin
          if (mac_done) begin
            launched <= 1'b0;
            if (last_fwd) begin
              tap   <= RW'(1);
              slot  <= pos_prev;
              state <= ST_FB;
            end else begin
              tap  <= tap + 1'b1;
              slot <= slot_prev;
            end
          end
        end
        ST_FB: begin
          if (mac_done) begin
            launched <= 1'b0;
            if (last_fb) begin
              state <= ST_SAT;
            end else begin
              tap  <= tap + 1'b1;
              slot <= slot_prev;
            end
          end
        end
        ST_SAT: begin
          y_val  <= y_sat;
          clip_y <= y_hit;
          state  <= ST_RND;
        end
        ST_RND: begin
          if (out_free) begin
            result.sample_out <= s_sat;
            result.clipped    <= clip_y | s_hit;
            result_valid      <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `IIR_CHK(a_pos_range, clk, rst, pos <= RW'(RING_DEPTH - 1))
  `IIR_CHK(a_fwd_tap_range, clk, rst, (state == ST_FWD) |-> (tap <= RW'(FORWARD_ORDER)))
  `IIR_CHK_NEXT(a_sat_to_rnd, clk, rst, state == ST_SAT, state == ST_RND)

endmodule

`default_nettype wire

@@ dv/iir_direct_form_one_filter_top_tb.sv @@
`default_nettype none

module iir_direct_form_one_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iirdf1_pkg::*;

  localparam int FWD_ORD   = FORWARD_ORDER_DEF;
  localparam int FB_ORD    = FEEDBACK_ORDER_DEF;
  localparam int RING      = ((FWD_ORD > FB_ORD) ? FWD_ORD : FB_ORD) + 1;
  localparam int LATENCY   = 6 * (FWD_ORD + FB_ORD + 1) + 2;
  localparam int WDOG_MAX  = 40 * LATENCY + 2000;

  // Filter state mirror and expected result queue
  class filter_scoreboard;
    logic signed [SAMPLE_W-1:0] x_hist[RING];
    logic signed [HIST_W-1:0]   y_hist[RING];
    logic signed [COEF_W-1:0]   b_coef[FWD_ORD+1];
    logic signed [COEF_W-1:0]   a_coef[FB_ORD+1];
    int unsigned                newest;
    result_t                    pending[$];
    int                         mismatches;

    function void clear_state();
      for (int k = 0; k < RING; k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
      foreach (b_coef[k]) b_coef[k] = '0;
      foreach (a_coef[k]) a_coef[k] = '0;
      newest = 0;
      pending.delete();
      mismatches = 0;
    endfunction

    // Note an accepted request; filter requests queue one expected result
    function void note_request(req_t r);
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] prod;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] s;
      int unsigned slot;
      result_t res;
      if (r.req_type == REQ_COEF) begin
        if (r.coef_bank == BANK_FWD) begin
          if (r.tap_number <= FWD_ORD) b_coef[r.tap_number] = r.coef_word;
        end else if (r.tap_number >= 1 && r.tap_number <= FB_ORD) begin
          a_coef[r.tap_number] = r.coef_word;
        end
        return;
      end
      newest = (newest + 1) % RING;
      x_hist[newest] = r.sample_in;
      acc = '0;
      for (int k = 0; k <= FWD_ORD; k++) begin
        slot = (newest + RING - k) % RING;
        acc += 64'(b_coef[k]) * 64'(x_hist[slot]);
      end
      for (int k = 1; k <= FB_ORD; k++) begin
        slot = (newest + RING - k) % RING;
        prod = 64'(a_coef[k]) * 64'(y_hist[slot]);
        acc -= prod >>> FB_SHIFT;
      end
      res.clipped = 1'b0;
      y = (acc + 64'sd128) >>> Y_SHIFT;
      if (y > Y_MAX) begin
        y = Y_MAX;
        res.clipped = 1'b1;
      end else if (y < Y_MIN) begin
        y = Y_MIN;
        res.clipped = 1'b1;
      end
      y_hist[newest] = y[HIST_W-1:0];
      s = (y + 64'sd32768) >>> S_SHIFT;
      if (s > 64'sd32767) begin
        s = 64'sd32767;
        res.clipped = 1'b1;
      end else if (s < -64'sd32768) begin
        s = -64'sd32768;
        res.clipped = 1'b1;
      end
      res.sample_out = s[SAMPLE_W-1:0];
      pending.push_back(res);
    endfunction

    // Compare a result transfer against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0b", got.sample_out, got.clipped);
        return;
      end
      want = pending.pop_front();
      if (got.sample_out !== want.sample_out || got.clipped !== want.clipped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %0d/%0b got %0d/%0b",
                   want.sample_out, want.clipped, got.sample_out, got.clipped);
      end
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    req_valid;
  logic    req_stall;
  req_t    req;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  filter_scoreboard sb;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      wdog;
  bit      timed_out;

  iir_direct_form_one_filter_top u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: check transfers, random stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    result_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (result_valid && !result_stall)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX && !timed_out) begin
        timed_out = 1'b1;
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Present one request and hold it until transferred; the caller drops valid
  task automatic send_request(req_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  function automatic req_t random_noise();
    logic [63:0] bits;
    req_t r;
    bits = {$urandom, $urandom};
    r = req_t'(bits[$bits(req_t)-1:0]);
    return r;
  endfunction

  task automatic write_coef(logic bank, int tap, logic signed [COEF_W-1:0] value);
    req_t r;
    r = random_noise();
    r.req_type = REQ_COEF;
    r.coef_bank = bank;
    r.tap_number = tap[TAP_W-1:0];
    r.coef_word = value;
    send_request(r);
  endtask

  task automatic filter_sample(logic signed [SAMPLE_W-1:0] x);
    req_t r;
    r = random_noise();
    r.req_type = REQ_FILTER;
    r.sample_in = x;
    send_request(r);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Small stable-ish coefficient set with random content
  task automatic load_random_bank(int gain_bits);
    for (int k = 0; k <= FWD_ORD; k++)
      write_coef(BANK_FWD, k, $signed($urandom) >>> (32 - gain_bits));
    for (int k = 1; k <= FB_ORD; k++)
      write_coef(BANK_FB, k, $signed($urandom) >>> (32 - gain_bits + 4));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  initial begin
    req_t r;
    sb = new();
    sb.clear_state();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    timed_out = 1'b0;
    wdog = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    result_stall = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero coefficients, extremes, ignored taps, identity and saturation
    filter_sample(16'sh7FFF);
    write_coef(BANK_FWD, 0, 32'sh0100_0000);
    filter_sample(16'sh7FFF);
    filter_sample(16'sh8000);
    write_coef(BANK_FB, 0, 32'sh7FFF_FFFF);
    write_coef(BANK_FB, 11, 32'sh7FFF_FFFF);
    write_coef(BANK_FWD, 15, 32'sh7FFF_FFFF);
    filter_sample(16'sh0001);
    write_coef(BANK_FWD, 10, 32'sh7FFF_FFFF);
    write_coef(BANK_FWD, 0, 32'sh7FFF_FFFF);
    filter_sample(16'sh7FFF);
    filter_sample(16'sh8000);
    write_coef(BANK_FB, 1, 32'sh8000_0000);
    write_coef(BANK_FB, 10, 32'sh7FFF_FFFF);
    for (int i = 0; i < 8; i++) filter_sample(random_sample());
    write_coef(BANK_FWD, 0, 32'sh0080_0000);
    write_coef(BANK_FWD, 10, 32'sh0000_0000);
    write_coef(BANK_FB, 1, 32'sh0000_0000);
    write_coef(BANK_FB, 10, 32'sh0000_0000);
    filter_sample(16'sh0001);
    filter_sample(16'shFFFF);
    wait_drained();

    // Random phases with different idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      load_random_bank(8 + $urandom_range(20));
      for (int i = 0; i < 220; i++) begin
        if ($urandom_range(19) == 0) begin
          r = random_noise();
          r.req_type = REQ_COEF;
          send_request(r);
        end else begin
          filter_sample(random_sample());
        end
        if (i == 110) wait_drained();
      end
      wait_drained();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/iirdf1_pkg.sv
src/iirdf1_mac.sv
src/iir_direct_form_one_filter_top.sv
dv/iir_direct_form_one_filter_top_tb.sv
